// ----- hw/rtl/swm_pkg.sv -----
`timescale 1ns / 1ps

package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SAMPLE_W   = 32;
  localparam int MED_W      = 33;
  localparam int CFG_W      = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_SIZE = 3'd0;
  localparam logic [CFG_W-1:0]      WINDOW_SIZE_RST  = 7'd3;

  typedef struct packed {
    logic ins;
    logic flush;
    logic del;
    logic clr;
  } swm_cell_ctl_t;

endpackage

// ----- hw/rtl/swm_in_if.sv -----
`timescale 1ns / 1ps

interface swm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swm_pkg::SAMPLE_W-1:0] sample;
  logic                                 restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

// ----- hw/rtl/swm_out_if.sv -----
`timescale 1ns / 1ps

interface swm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [swm_pkg::MED_W-1:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink (input valid, input median_doubled, output ready);
endinterface

// ----- hw/rtl/swm_cell.sv -----
`timescale 1ns / 1ps

module swm_cell #(
  parameter int SB = swm_pkg::SAMPLE_BITS_DEF,
  parameter int AW = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swm_pkg::swm_cell_ctl_t ctl,
  input  logic [SB-1:0]         new_val,
  input  logic [AW-1:0]         old_age,
  input  logic [SB-1:0]         left_val,
  input  logic [AW-1:0]         left_age,
  input  logic                  left_take,
  input  logic                  left_valid,
  input  logic [SB-1:0]         right_val,
  input  logic [AW-1:0]         right_age,
  input  logic                  right_valid,
  input  logic                  past_in,
  output logic [SB-1:0]         val,
  output logic [AW-1:0]         age,
  output logic                  valid,
  output logic                  take,
  output logic                  past_out
);
  import swm_pkg::*;

  logic [SB-1:0] val_r, val_nxt;
  logic [AW-1:0] age_r, age_nxt;
  logic          valid_r, valid_nxt;
  logic          eff_valid;
  logic          hit;

  assign eff_valid = valid_r && !ctl.flush;
  assign take      = !eff_valid || ($signed(val_r) > $signed(new_val));
  assign hit       = valid_r && (age_r == old_age);
  assign past_out  = past_in || hit;

  assign val   = val_r;
  assign age   = age_r;
  assign valid = eff_valid;

  always_comb begin
    val_nxt   = val_r;
    age_nxt   = age_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins) begin
      if (take) begin
        val_nxt   = left_take ? left_val : new_val;
        age_nxt   = left_take ? AW'(left_age + AW'(1)) : '0;
        valid_nxt = eff_valid || left_valid;
      end else begin
        age_nxt   = AW'(age_r + AW'(1));
        valid_nxt = eff_valid;
      end
    end else if (ctl.del && past_out) begin
      val_nxt   = right_val;
      age_nxt   = right_age;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    val_r <= val_nxt;
    age_r <= age_nxt;
  end

endmodule

// ----- hw/rtl/sliding_window_median_core.sv -----
`timescale 1ns / 1ps

// channel   dir   handshake          payload
// in_ch     in    valid/ready        sample, restart
// out_ch    out   valid/ready        median_doubled
// cfg_*     in    apb write/read     window_size at byte address 0
//
// a sample runs through these steps, and one that gives no result ends
// after the second with no median pick or removal: insert into the cell row,
// then median pick and oldest-entry removal, then the add into the output register
// in_ch.ready is low until the current sample is done; a full output
// register that is not taken holds the block in its add cycle
// reset is synchronous and empties the cell row and the output register

module sliding_window_median_core #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  swm_in_if.sink                           in_ch,
  swm_out_if.source                        out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [swm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [swm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [swm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import swm_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int KW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SUM} state_t;

  state_t           state_r, state_nxt;
  logic [KW-1:0]    fill_r, fill_nxt;
  logic             full_r, full_nxt;
  logic [SB-1:0]    lo_r, lo_nxt;
  logic [SB-1:0]    hi_r, hi_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [MED_W-1:0] out_data_r, out_data_nxt;
  logic [CFG_W-1:0] ws_r;

  logic             cfg_wr;
  logic [KW-1:0]    keff;
  logic [KW-1:0]    lo_idx;
  logic [KW-1:0]    hi_idx;
  logic [AW-1:0]    old_age;
  logic             in_xfer;
  logic             flush_cond;
  logic [KW-1:0]    fill_start;
  logic [SB-1:0]    lo_pick;
  logic [SB-1:0]    hi_pick;
  logic [SB:0]      sum_w;
  swm_cell_ctl_t    cell_ctl;

  logic [SB-1:0]    cell_val   [WINDOW_MAX];
  logic [AW-1:0]    cell_age   [WINDOW_MAX];
  logic             cell_valid [WINDOW_MAX];
  logic             cell_take  [WINDOW_MAX];
  logic             cell_past  [WINDOW_MAX];

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DATA_W'(ws_r);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == ADDR_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WINDOW_SIZE_RST;
    end else if (cfg_wr) begin
      ws_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (ws_r == '0) begin
      keff = KW'(1);
    end else if (int'(ws_r) > WINDOW_MAX) begin
      keff = KW'(WINDOW_MAX);
    end else begin
      keff = KW'(ws_r);
    end
  end

  assign lo_idx  = KW'((keff - KW'(1)) >> 1);
  assign hi_idx  = KW'(keff >> 1);
  assign old_age = AW'(keff - KW'(1));

  // input side
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign flush_cond  = in_ch.restart || (fill_r >= keff);
  assign fill_start  = flush_cond ? '0 : fill_r;

  assign cell_ctl.ins   = in_xfer;
  assign cell_ctl.flush = in_xfer && flush_cond;
  assign cell_ctl.del   = (state_r == S_EVAL) && full_r;
  assign cell_ctl.clr   = cfg_wr;

  // row of sorted cells
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SB-1:0] l_val;
    logic [AW-1:0] l_age;
    logic          l_take;
    logic          l_valid;
    logic [SB-1:0] r_val;
    logic [AW-1:0] r_age;
    logic          r_valid;
    logic          p_in;

    if (i == 0) begin : g_head
      assign l_val   = '0;
      assign l_age   = '0;
      assign l_take  = 1'b0;
      assign l_valid = 1'b1;
      assign p_in    = 1'b0;
    end else begin : g_body
      assign l_val   = cell_val[i-1];
      assign l_age   = cell_age[i-1];
      assign l_take  = cell_take[i-1];
      assign l_valid = cell_valid[i-1];
      assign p_in    = cell_past[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign r_val   = '0;
      assign r_age   = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_val   = cell_val[i+1];
      assign r_age   = cell_age[i+1];
      assign r_valid = cell_valid[i+1];
    end

    swm_cell #(
      .SB (SB),
      .AW (AW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl),
      .new_val     (in_ch.sample[SB-1:0]),
      .old_age     (old_age),
      .left_val    (l_val),
      .left_age    (l_age),
      .left_take   (l_take),
      .left_valid  (l_valid),
      .right_val   (r_val),
      .right_age   (r_age),
      .right_valid (r_valid),
      .past_in     (p_in),
      .val         (cell_val[i]),
      .age         (cell_age[i]),
      .valid       (cell_valid[i]),
      .take        (cell_take[i]),
      .past_out    (cell_past[i])
    );
  end

  // middle taps
  always_comb begin
    lo_pick = '0;
    hi_pick = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (KW'(i) == lo_idx) begin
        lo_pick = cell_val[i];
      end
      if (KW'(i) == hi_idx) begin
        hi_pick = cell_val[i];
      end
    end
  end

  assign sum_w = {lo_r[SB-1], lo_r} + {hi_r[SB-1], hi_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    full_nxt      = full_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          fill_nxt  = KW'(fill_start + KW'(1));
          full_nxt  = (KW'(fill_start + KW'(1)) == keff);
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (full_r) begin
          lo_nxt    = lo_pick;
          hi_nxt    = hi_pick;
          fill_nxt  = KW'(fill_r - KW'(1));
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SUM: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt  = MED_W'(sum_w);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_wr) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.median_doubled = out_data_r;

endmodule

// ----- hw/rtl/swm_checker.sv -----
`timescale 1ns / 1ps

module swm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a result waits until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one sample at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in work");

  // a fresh result follows an input transfer through the evaluation and add states
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result without matching input transfer");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind sliding_window_median_core swm_checker u_swm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
